// ===== hdl/nsh_pkg.sv =====
// ----------------------------------------------------------------------------
// nsh_pkg
// Shared types and constants of the n-gram and skip-gram histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none
package nsh_pkg;
  localparam int unsigned ALPHABET_SIZE_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF    = 32;
  localparam int unsigned TOTAL_BITS_DEF    = 40;
  localparam int unsigned SYM_W             = 5;
  localparam int unsigned KIND_W            = 3;
  localparam int unsigned OUT_COUNT_W       = 32;
  localparam int unsigned OUT_TOTAL_W       = 40;
  localparam int unsigned NUM_TABLES        = 6;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_EOW  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  localparam logic [KIND_W-1:0] KIND_CHAR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BI   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRI  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SK1  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SK2  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SK3  = 3'd5;

  // classified operation passed from front to back
  typedef struct packed {
    logic              is_read;
    logic [5:0]        upd;     // which tables to bump, query_kind order
    logic [SYM_W-1:0]  s;
    logic [SYM_W-1:0]  h0;
    logic [SYM_W-1:0]  h1;
    logic [SYM_W-1:0]  h2;
    logic [SYM_W-1:0]  h3;
    logic [KIND_W-1:0] kind;
    logic              key_ok;
    logic [SYM_W-1:0]  ka;
    logic [SYM_W-1:0]  kb;
    logic [SYM_W-1:0]  kc;
  } op_t;
endpackage
`default_nettype wire

// ===== hdl/nsh_if.sv =====
// ----------------------------------------------------------------------------
// nsh_in_if / nsh_out_if
// Valid/ready channels of the histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none
interface nsh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] symbol;
  logic [2:0] query_kind;
  logic [4:0] key_a;
  logic [4:0] key_b;
  logic [4:0] key_c;
  modport source (output valid, cmd, symbol, query_kind, key_a, key_b, key_c,
                  input ready);
  modport sink (input valid, cmd, symbol, query_kind, key_a, key_b, key_c,
                output ready);
endinterface

interface nsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] count;
  logic [39:0] table_total;
  modport source (output valid, count, table_total, input ready);
  modport sink (input valid, count, table_total, output ready);
endinterface
`default_nettype wire

// ===== hdl/nsh_front.sv =====
// ----------------------------------------------------------------------------
// nsh_front
// Accept beats, track word history, classify into table operations.
// ----------------------------------------------------------------------------
`default_nettype none
module nsh_front #(
  parameter int unsigned ALPHABET_SIZE = nsh_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  nsh_in_if.sink             in_ch,
  output nsh_pkg::op_t       op_o,
  output logic               op_valid_o,
  input  wire logic          op_ready_i
);
  import nsh_pkg::*;

  logic [SYM_W-1:0] hist_r [4];
  logic [2:0]       pos_r;
  logic             sym_ok, ka_ok, kb_ok, kc_ok, acc;
  cmd_t             cmd;
  op_t              op;

  assign cmd         = cmd_t'(in_ch.cmd);
  assign in_ch.ready = op_ready_i;
  assign acc         = in_ch.valid && op_ready_i;
  assign sym_ok = ({2'b00, in_ch.symbol} < 7'(ALPHABET_SIZE));
  assign ka_ok  = ({2'b00, in_ch.key_a} < 7'(ALPHABET_SIZE));
  assign kb_ok  = ({2'b00, in_ch.key_b} < 7'(ALPHABET_SIZE));
  assign kc_ok  = ({2'b00, in_ch.key_c} < 7'(ALPHABET_SIZE));

  always_comb begin
    op          = '0;
    op.s        = in_ch.symbol;
    op.h0       = hist_r[0];
    op.h1       = hist_r[1];
    op.h2       = hist_r[2];
    op.h3       = hist_r[3];
    op.kind     = in_ch.query_kind;
    op.ka       = in_ch.key_a;
    op.kb       = in_ch.key_b;
    op.kc       = in_ch.key_c;
    op.is_read  = (cmd == CMD_READ);
    unique case (in_ch.query_kind)
      KIND_CHAR: op.key_ok = ka_ok;
      KIND_TRI:  op.key_ok = ka_ok && kb_ok && kc_ok;
      default:   op.key_ok = ka_ok && kb_ok;
    endcase
    if (cmd == CMD_ADD && sym_ok) begin
      op.upd[0] = 1'b1;
      op.upd[1] = (pos_r >= 3'd1);
      op.upd[2] = (pos_r >= 3'd2);
      op.upd[3] = (pos_r >= 3'd2);
      op.upd[4] = (pos_r >= 3'd3);
      op.upd[5] = (pos_r >= 3'd4);
    end
  end

  assign op_o       = op;
  assign op_valid_o = in_ch.valid && (op.is_read || (op.upd != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < 4; i++) hist_r[i] <= '0;
    end else if (acc) begin
      if (cmd == CMD_EOW) begin
        pos_r <= '0;
        for (int i = 0; i < 4; i++) hist_r[i] <= '0;
      end else if (cmd == CMD_ADD && sym_ok) begin
        hist_r[3] <= hist_r[2];
        hist_r[2] <= hist_r[1];
        hist_r[1] <= hist_r[0];
        hist_r[0] <= in_ch.symbol;
        if (pos_r < 3'd4) pos_r <= pos_r + 3'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_max: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= 3'd4)
    else $error("word position overflow");
  a_eow_clr: assert property (@(posedge clk) disable iff (!rst_n)
    acc && cmd == CMD_EOW |=> pos_r == 3'd0)
    else $error("end of word did not clear history");
  a_upd_chain: assert property (@(posedge clk) disable iff (!rst_n)
    op.upd[5] |-> op.upd[4] && op.upd[1])
    else $error("update mask inconsistent");
`endif
endmodule
`default_nettype wire

// ===== hdl/nsh_fifo.sv =====
// ----------------------------------------------------------------------------
// nsh_fifo
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module nsh_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire nsh_pkg::op_t wr_data,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  output nsh_pkg::op_t      rd_data,
  output logic              rd_valid,
  input  wire logic         rd_ready
);
  import nsh_pkg::*;

  op_t        mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("queue pointers out of step");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !pop |=> cnt_r == 2'd2)
    else $error("queue lost an entry");
`endif
endmodule
`default_nettype wire

// ===== hdl/nsh_back.sv =====
// ----------------------------------------------------------------------------
// nsh_back
// Count tables and totals: clear sweep, read-modify-write, query reads.
// ----------------------------------------------------------------------------
`default_nettype none
module nsh_back #(
  parameter int unsigned ALPHABET_SIZE = nsh_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned COUNT_BITS    = nsh_pkg::COUNT_BITS_DEF,
  parameter int unsigned TOTAL_BITS    = nsh_pkg::TOTAL_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire nsh_pkg::op_t op_i,
  input  wire logic         op_valid_i,
  output logic              op_ready_o,
  nsh_out_if.source         out_ch
);
  import nsh_pkg::*;

  localparam int unsigned AW    = (ALPHABET_SIZE <= 2) ? 1 : $clog2(ALPHABET_SIZE);
  localparam int unsigned PW    = 2 * AW;
  localparam int unsigned TW    = 3 * AW;
  localparam int unsigned SW    = TW + 1;
  localparam int unsigned CDEP  = 1 << AW;
  localparam int unsigned PDEP  = 1 << PW;
  localparam int unsigned TDEP  = 1 << TW;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [TOTAL_BITS-1:0] TMAX = '1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_WR, S_OUT} st_t;

  logic [COUNT_BITS-1:0] m_char [CDEP];
  logic [COUNT_BITS-1:0] m_bi   [PDEP];
  logic [COUNT_BITS-1:0] m_tri  [TDEP];
  logic [COUNT_BITS-1:0] m_s1   [PDEP];
  logic [COUNT_BITS-1:0] m_s2   [PDEP];
  logic [COUNT_BITS-1:0] m_s3   [PDEP];
  logic [TOTAL_BITS-1:0] tot_r  [NUM_TABLES];

  st_t             st_r;
  logic [SW-1:0]   clr_r;
  op_t             op_r;
  logic [AW-1:0]   a_c, a_1, a_s1, a_s2, a_s3, q_a;
  logic [PW-1:0]   a_bi, q_p;
  logic [TW-1:0]   a_tri, q_t;
  logic [COUNT_BITS-1:0] rd_r [NUM_TABLES];
  logic            clr_go, clr_done;
  logic [COUNT_BITS-1:0] sel_cnt;
  logic [TOTAL_BITS-1:0] sel_tot;
  logic            ov_r;
  logic [OUT_COUNT_W-1:0] cnt_o_r;
  logic [OUT_TOTAL_W-1:0] tot_o_r;

  assign a_1   = op_r.s[AW-1:0];
  assign a_c   = a_1;
  assign a_bi  = {op_r.h0[AW-1:0], a_1};
  assign a_tri = {op_r.h1[AW-1:0], op_r.h0[AW-1:0], a_1};
  assign a_s1  = op_r.h1[AW-1:0];
  assign a_s2  = op_r.h2[AW-1:0];
  assign a_s3  = op_r.h3[AW-1:0];
  assign q_a   = op_r.ka[AW-1:0];
  assign q_p   = {op_r.ka[AW-1:0], op_r.kb[AW-1:0]};
  assign q_t   = {op_r.ka[AW-1:0], op_r.kb[AW-1:0], op_r.kc[AW-1:0]};
  assign clr_go   = (st_r == S_CLEAR);
  assign clr_done = (clr_r == SW'(TDEP - 1));

  // memories: clear sweep, or read for a query or an update, then increment
  always_ff @(posedge clk) begin
    if (clr_go) begin
      m_tri[clr_r[TW-1:0]] <= '0;
      if (clr_r < SW'(PDEP)) begin
        m_bi[clr_r[PW-1:0]] <= '0;
        m_s1[clr_r[PW-1:0]] <= '0;
        m_s2[clr_r[PW-1:0]] <= '0;
        m_s3[clr_r[PW-1:0]] <= '0;
      end
      if (clr_r < SW'(CDEP)) m_char[clr_r[AW-1:0]] <= '0;
    end else if (st_r == S_RD) begin
      if (op_r.is_read) begin
        rd_r[0] <= m_char[q_a];
        rd_r[1] <= m_bi[q_p];
        rd_r[2] <= m_tri[q_t];
        rd_r[3] <= m_s1[q_p];
        rd_r[4] <= m_s2[q_p];
        rd_r[5] <= m_s3[q_p];
      end else begin
        rd_r[0] <= m_char[a_c];
        rd_r[1] <= m_bi[a_bi];
        rd_r[2] <= m_tri[a_tri];
        rd_r[3] <= m_s1[{a_s1, a_1}];
        rd_r[4] <= m_s2[{a_s2, a_1}];
        rd_r[5] <= m_s3[{a_s3, a_1}];
      end
    end else if (st_r == S_WR) begin
      if (op_r.upd[0] && rd_r[0] != CMAX) m_char[a_c] <= rd_r[0] + 1'b1;
      if (op_r.upd[1] && rd_r[1] != CMAX) m_bi[a_bi] <= rd_r[1] + 1'b1;
      if (op_r.upd[2] && rd_r[2] != CMAX) m_tri[a_tri] <= rd_r[2] + 1'b1;
      if (op_r.upd[3] && rd_r[3] != CMAX) m_s1[{a_s1, a_1}] <= rd_r[3] + 1'b1;
      if (op_r.upd[4] && rd_r[4] != CMAX) m_s2[{a_s2, a_1}] <= rd_r[4] + 1'b1;
      if (op_r.upd[5] && rd_r[5] != CMAX) m_s3[{a_s3, a_1}] <= rd_r[5] + 1'b1;
    end
  end

  always_comb begin
    sel_cnt = '0;
    sel_tot = '0;
    unique case (op_r.kind)
      KIND_CHAR: begin sel_cnt = rd_r[0]; sel_tot = tot_r[0]; end
      KIND_BI:   begin sel_cnt = rd_r[1]; sel_tot = tot_r[1]; end
      KIND_TRI:  begin sel_cnt = rd_r[2]; sel_tot = tot_r[2]; end
      KIND_SK1:  begin sel_cnt = rd_r[3]; sel_tot = tot_r[3]; end
      KIND_SK2:  begin sel_cnt = rd_r[4]; sel_tot = tot_r[4]; end
      KIND_SK3:  begin sel_cnt = rd_r[5]; sel_tot = tot_r[5]; end
      default: ;
    endcase
    if (!op_r.key_ok) sel_cnt = '0;
  end

  // clamp to output widths
  function automatic logic [OUT_COUNT_W-1:0] clamp_c(input logic [COUNT_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    clamp_c = (w > 64'({OUT_COUNT_W{1'b1}})) ? '1 : w[OUT_COUNT_W-1:0];
  endfunction
  function automatic logic [OUT_TOTAL_W-1:0] clamp_t(input logic [TOTAL_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    clamp_t = (w > 64'({OUT_TOTAL_W{1'b1}})) ? '1 : w[OUT_TOTAL_W-1:0];
  endfunction

  assign op_ready_o        = (st_r == S_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.count      = cnt_o_r;
  assign out_ch.table_total = tot_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
      for (int i = 0; i < NUM_TABLES; i++) tot_r[i] <= '0;
    end else begin
      unique case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_done) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (op_valid_i) begin
            op_r <= op_i;
            st_r <= S_RD;
          end
        end
        S_RD: st_r <= op_r.is_read ? S_OUT : S_WR;
        S_WR: begin
          for (int i = 0; i < NUM_TABLES; i++)
            if (op_r.upd[i] && tot_r[i] != TMAX) tot_r[i] <= tot_r[i] + 1'b1;
          st_r <= S_IDLE;
        end
        S_OUT: begin
          if (!ov_r || out_ch.ready) begin
            ov_r    <= 1'b1;
            cnt_o_r <= clamp_c(sel_cnt);
            tot_o_r <= clamp_t(sel_tot);
            st_r    <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
      if (ov_r && out_ch.ready && !(st_r == S_OUT)) ov_r <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_take_clr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CLEAR |-> !op_ready_o && !ov_r)
    else $error("operation taken during clear");
  a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_RD && !op_r.is_read |=> st_r == S_WR)
    else $error("update skipped write");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(cnt_o_r) && $stable(tot_o_r))
    else $error("result dropped under stall");
`endif
endmodule
`default_nettype wire

// ===== hdl/ngram_skipgram_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// ngram_skipgram_histogram_unit
// Character, bigram, trigram and skip-gram histograms with totals.
// ----------------------------------------------------------------------------
// Input channel in_*: one beat per command (add symbol, end of word, read).
// Output channel out_*: one beat per read, carrying count and table total.
// The front tracks the word history and classifies each beat in the cycle it
// arrives; end-of-word, ignored adds and unknown commands finish there.
// A two-entry queue feeds the back, which runs each table operation through
// a read cycle of the count memories and then a write cycle (add) or an
// output cycle (read), and takes no new operation until it is back in idle.
// A read reaches out_valid through the queue and the back's idle, read and output states.
// After reset the back sweeps the count memories to zero, one address per
// cycle over 2^(3*clog2(ALPHABET_SIZE)) addresses (32768 by default); input
// beats queue and then stall until it ends.
// When out_ready is low the result register holds, further reads stall in
// the back, and the queue then backs up to in_ready.
// ----------------------------------------------------------------------------
`default_nettype none
module ngram_skipgram_histogram_unit #(
  parameter int unsigned ALPHABET_SIZE = nsh_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned COUNT_BITS    = nsh_pkg::COUNT_BITS_DEF,
  parameter int unsigned TOTAL_BITS    = nsh_pkg::TOTAL_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nsh_in_if.sink    in_ch,
  nsh_out_if.source out_ch
);
  import nsh_pkg::*;

  op_t  f_op, b_op;
  logic f_valid, f_ready, b_valid, b_ready;

  nsh_front #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
    .clk, .rst_n, .in_ch,
    .op_o(f_op), .op_valid_o(f_valid), .op_ready_i(f_ready)
  );

  nsh_fifo u_fifo (
    .clk, .rst_n,
    .wr_data(f_op), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(b_op), .rd_valid(b_valid), .rd_ready(b_ready)
  );

  nsh_back #(
    .ALPHABET_SIZE(ALPHABET_SIZE), .COUNT_BITS(COUNT_BITS), .TOTAL_BITS(TOTAL_BITS)
  ) u_back (
    .clk, .rst_n,
    .op_i(b_op), .op_valid_i(b_valid), .op_ready_o(b_ready), .out_ch
  );
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the n-gram and skip-gram histogram unit. A directed
// stimulus table is followed by random words, reads and junk beats. Every
// accepted beat is applied to a local histogram model that predicts each read
// result. The bench idles the sender and stalls the receiver in phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import nsh_pkg::*;

  localparam int NUM_ITEMS = 1650;
  localparam int WATCHDOG_LIMIT = 120000;

  typedef struct {
    cmd_t             cmd;
    logic [4:0]       symbol;
    logic [2:0]       kind;
    logic [4:0]       ka;
    logic [4:0]       kb;
    logic [4:0]       kc;
    bit               typed;
    logic [31:0]      t_count;
    logic [39:0]      t_total;
  } beat_t;

  typedef struct {
    logic [31:0] count;
    logic [39:0] total;
  } read_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nsh_in_if  in_ch ();
  nsh_out_if out_ch ();

  ngram_skipgram_histogram_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // histogram model state
  logic [31:0] char_hist [32];
  logic [31:0] pair_hist [4][1024];  // bigram, skip1, skip2, skip3
  logic [31:0] tri_hist [32768];
  logic [39:0] gram_sum [6];
  logic [4:0]  word_hist [4];
  int          word_len;

  read_result_t pending_reads [$];
  int  mismatches = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  quiet_cycles = 0;
  int  beats_sent = 0;
  logic [4:0] last_word [8];
  int  last_word_len = 0;

  function automatic logic [31:0] sat32(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void tally(int k);
    if (gram_sum[k] != '1) gram_sum[k] = gram_sum[k] + 40'd1;
  endfunction

  function automatic void histogram_apply(beat_t b, output bit has_read,
                                          output read_result_t r);
    logic [4:0] s;
    has_read = 0;
    r.count = '0;
    r.total = '0;
    s = b.symbol;
    case (b.cmd)
      CMD_ADD: begin
        char_hist[s] = sat32(char_hist[s]);
        tally(KIND_CHAR);
        if (word_len >= 1) begin
          pair_hist[0][{word_hist[0], s}] = sat32(pair_hist[0][{word_hist[0], s}]);
          tally(KIND_BI);
        end
        if (word_len >= 2) begin
          tri_hist[{word_hist[1], word_hist[0], s}] =
            sat32(tri_hist[{word_hist[1], word_hist[0], s}]);
          tally(KIND_TRI);
          pair_hist[1][{word_hist[1], s}] = sat32(pair_hist[1][{word_hist[1], s}]);
          tally(KIND_SK1);
        end
        if (word_len >= 3) begin
          pair_hist[2][{word_hist[2], s}] = sat32(pair_hist[2][{word_hist[2], s}]);
          tally(KIND_SK2);
        end
        if (word_len >= 4) begin
          pair_hist[3][{word_hist[3], s}] = sat32(pair_hist[3][{word_hist[3], s}]);
          tally(KIND_SK3);
        end
        word_hist[3] = word_hist[2];
        word_hist[2] = word_hist[1];
        word_hist[1] = word_hist[0];
        word_hist[0] = s;
        if (word_len < 4) word_len++;
      end
      CMD_EOW: begin
        foreach (word_hist[i]) word_hist[i] = '0;
        word_len = 0;
      end
      CMD_READ: begin
        has_read = 1;
        if (b.kind < NUM_TABLES) begin
          r.total = gram_sum[b.kind];
          case (b.kind)
            KIND_CHAR: r.count = char_hist[b.ka];
            KIND_BI:   r.count = pair_hist[0][{b.ka, b.kb}];
            KIND_TRI:  r.count = tri_hist[{b.ka, b.kb, b.kc}];
            KIND_SK1:  r.count = pair_hist[1][{b.ka, b.kb}];
            KIND_SK2:  r.count = pair_hist[2][{b.ka, b.kb}];
            default:   r.count = pair_hist[3][{b.ka, b.kb}];
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(beat_t b);
    bit has_read;
    read_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= b.cmd;
    in_ch.symbol     <= b.symbol;
    in_ch.query_kind <= b.kind;
    in_ch.key_a      <= b.ka;
    in_ch.key_b      <= b.kb;
    in_ch.key_c      <= b.kc;
    do @(posedge clk); while (!in_ch.ready);
    histogram_apply(b, has_read, r);
    if (has_read) begin
      if (b.typed) begin
        r.count = b.t_count;
        r.total = b.t_total;
      end
      pending_reads.push_back(r);
    end
    beats_sent++;
  endtask

  function automatic beat_t mk(cmd_t c, int s, logic [2:0] k, int a, int b2, int c2);
    beat_t b;
    b.cmd = c;
    b.symbol = 5'(s);
    b.kind = k;
    b.ka = 5'(a);
    b.kb = 5'(b2);
    b.kc = 5'(c2);
    b.typed = 0;
    b.t_count = '0;
    b.t_total = '0;
    return b;
  endfunction

  function automatic beat_t mk_typed(logic [2:0] k, int a, int b2, int c2,
                                     logic [31:0] cnt, logic [39:0] tot);
    beat_t b;
    b = mk(CMD_READ, 0, k, a, b2, c2);
    b.typed = 1;
    b.t_count = cnt;
    b.t_total = tot;
    return b;
  endfunction

  function automatic logic [4:0] rand_sym();
    return ($urandom_range(1)) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
  endfunction

  function automatic logic [4:0] rand_key();
    if (last_word_len > 0 && $urandom_range(3) != 0)
      return last_word[$urandom_range(last_word_len - 1)];
    return rand_sym();
  endfunction

  // check read results
  always @(posedge clk) begin
    read_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected read beat: count=%0d total=%0d",
                   out_ch.count, out_ch.table_total);
      end else begin
        want = pending_reads.pop_front();
        if (out_ch.count !== want.count || out_ch.table_total !== want.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read mismatch: count exp=%0d act=%0d total exp=%0d act=%0d",
                     want.count, out_ch.count, want.total, out_ch.table_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    beat_t dir [$];
    int n;
    int r;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NOP;
    in_ch.symbol = '0;
    in_ch.query_kind = '0;
    in_ch.key_a = '0;
    in_ch.key_b = '0;
    in_ch.key_c = '0;
    out_ch.ready = 1'b1;
    foreach (char_hist[i]) char_hist[i] = '0;
    foreach (pair_hist[i, j]) pair_hist[i][j] = '0;
    foreach (tri_hist[i]) tri_hist[i] = '0;
    foreach (gram_sum[i]) gram_sum[i] = '0;
    foreach (word_hist[i]) word_hist[i] = '0;
    word_len = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty tables, empty word end, junk commands, a short word, reads of every kind, unknown kinds
    dir.push_back(mk_typed(KIND_CHAR, 0, 0, 0, 32'd0, 40'd0));
    dir.push_back(mk_typed(KIND_TRI, 31, 31, 31, 32'd0, 40'd0));
    dir.push_back(mk_typed(KIND_SK3, 31, 0, 0, 32'd0, 40'd0));
    dir.push_back(mk(CMD_EOW, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_NOP, 31, 7, 31, 31, 31));
    dir.push_back(mk(CMD_ADD, 31, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ADD, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ADD, 31, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ADD, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ADD, 21, 7, 31, 31, 31));
    dir.push_back(mk(CMD_ADD, 10, 0, 0, 0, 0));
    dir.push_back(mk(CMD_EOW, 0, 0, 0, 0, 0));
    dir.push_back(mk(CMD_READ, 0, KIND_CHAR, 31, 0, 0));
    dir.push_back(mk(CMD_READ, 0, KIND_BI, 31, 0, 0));
    dir.push_back(mk(CMD_READ, 0, KIND_TRI, 31, 0, 31));
    dir.push_back(mk(CMD_READ, 0, KIND_SK1, 31, 31, 0));
    dir.push_back(mk(CMD_READ, 0, KIND_SK2, 31, 0, 0));
    dir.push_back(mk(CMD_READ, 0, KIND_SK3, 31, 21, 0));
    dir.push_back(mk(CMD_READ, 0, KIND_SK3, 0, 10, 0));
    dir.push_back(mk_typed(3'd6, 31, 0, 0, 32'd0, 40'd0));
    dir.push_back(mk_typed(3'd7, 0, 31, 31, 32'd0, 40'd0));
    foreach (dir[i]) send_beat(dir[i]);

    while (beats_sent < NUM_ITEMS) begin
      n = beats_sent * 4 / NUM_ITEMS;
      idle_pct  = (n == 1) ? 61 : (n == 3) ? 10 : 0;
      stall_pct = (n == 2) ? 61 : (n == 3) ? 10 : 0;
      r = $urandom_range(99);
      if (r < 65) begin
        last_word_len = $urandom_range(7);
        for (int i = 0; i < last_word_len; i++) begin
          last_word[i] = rand_sym();
          send_beat(mk(CMD_ADD, last_word[i], 3'($urandom_range(7)),
                       $urandom_range(31), $urandom_range(31), $urandom_range(31)));
          if ($urandom_range(9) == 0)
            send_beat(mk(CMD_READ, 0, 3'($urandom_range(5)),
                         rand_key(), rand_key(), rand_key()));
        end
        if ($urandom_range(9) != 0)
          send_beat(mk(CMD_EOW, $urandom_range(31), 3'($urandom_range(7)),
                       $urandom_range(31), $urandom_range(31), $urandom_range(31)));
      end else if (r < 93) begin
        send_beat(mk(CMD_READ, $urandom_range(31),
                     ($urandom_range(9) == 0) ? 3'($urandom_range(7)) :
                                                3'($urandom_range(5)),
                     rand_key(), rand_key(), rand_key()));
      end else begin
        send_beat(mk(CMD_NOP, $urandom_range(31), 3'($urandom_range(7)),
                     $urandom_range(31), $urandom_range(31), $urandom_range(31)));
      end
    end
    in_ch.valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/nsh_pkg.sv
hdl/nsh_if.sv
hdl/nsh_front.sv
hdl/nsh_fifo.sv
hdl/nsh_back.sv
hdl/ngram_skipgram_histogram_unit.sv
verif/tb_top.sv
